// ===== design/cordic_sine_cosine_core_assert.svh =====
// assertion macros for the cordic sine/cosine core
`ifndef CORDIC_SINE_COSINE_CORE_ASSERT_SVH
`define CORDIC_SINE_COSINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csc implication check failed");
// next-cycle implication, checked out of reset
`define CSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csc next-cycle check failed");
`else
`define CSC_ASSERT_IMPL(label, ante, cons)
`define CSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/csc_pkg.sv =====
// shared types, constants and arctangent table for the cordic sine/cosine core
package csc_pkg;

    localparam int DATA_W         = 32;
    localparam int CNT_W          = 6;
    localparam int MAX_ITERATIONS = 32;
    localparam int STAGE_IDX_W    = $clog2(MAX_ITERATIONS);
    localparam int LATENCY        = MAX_ITERATIONS;

    // reciprocal cordic gain for the full table, q2.30
    localparam logic signed [DATA_W-1:0] GAIN_INIT = 32'sh26DD3B6A;

    // atan(2^-k) in q2.30
    localparam logic [DATA_W-1:0] ATAN_TABLE [MAX_ITERATIONS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic        [CNT_W-1:0]  n;
    } t_vec;

endpackage

// ===== design/csc_stage.sv =====
// one registered cordic micro-rotation stage
module csc_stage
    import csc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [STAGE_IDX_W-1:0] i_idx,
    input  logic                   i_valid,
    input  t_vec                   i_vec,
    output logic                   o_valid,
    output t_vec                   o_vec
);

    logic                     r_valid;
    t_vec                     r_vec;
    t_vec                     n_vec;
    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] ys;
    logic signed [DATA_W-1:0] a;
    logic                     active;

    always_comb begin
        xs     = i_vec.x >>> i_idx;
        ys     = i_vec.y >>> i_idx;
        a      = $signed(ATAN_TABLE[i_idx]);
        active = CNT_W'(i_idx) < i_vec.n;
        n_vec  = i_vec;
        if (active) begin
            // rotate toward zero residual angle
            if (!i_vec.z[DATA_W-1]) begin
                n_vec.x = i_vec.x - ys;
                n_vec.y = i_vec.y + xs;
                n_vec.z = i_vec.z - a;
            end else begin
                n_vec.x = i_vec.x + ys;
                n_vec.y = i_vec.y - xs;
                n_vec.z = i_vec.z + a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// ===== design/cordic_sine_cosine_core.sv =====
// cordic sine/cosine core: one angle in, sine and cosine out, fully pipelined
//
//  channel   ports                          direction  handshake
//  -------   -----------------------------  ---------  ---------------------------
//  command   start, busy, i_angle           in (busy)  start high, busy low
//  result    o_valid, o_sine, o_cosine      out        one-cycle strobe on o_valid
//  config    i_cfg_wr_en, i_cfg_wr_data     in         write when i_cfg_wr_en high
//
// one angle can be taken every cycle; each result passes through one register
// stage per micro-rotation on its way to the outputs.
// busy stays low: the pipeline never stalls and results cannot be held off.
// synchronous active-low reset clears the valid bits and sets the count to 32.
// the iteration count travels with each transaction through the stages.
module cordic_sine_cosine_core
    import csc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_angle,
    input  logic                     i_cfg_wr_en,
    input  logic [CNT_W-1:0]         i_cfg_wr_data,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_sine,
    output logic signed [DATA_W-1:0] o_cosine
);

    `include "cordic_sine_cosine_core_assert.svh"

    logic [CNT_W-1:0] r_iter_count;
    logic [CNT_W-1:0] n_iter_count;
    logic             w_valid [MAX_ITERATIONS+1];
    t_vec             w_vec   [MAX_ITERATIONS+1];

    // counts above the table size saturate
    always_comb begin
        n_iter_count = r_iter_count;
        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data > CNT_W'(MAX_ITERATIONS)) begin
                n_iter_count = CNT_W'(MAX_ITERATIONS);
            end else begin
                n_iter_count = i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_count <= CNT_W'(MAX_ITERATIONS);
        end else begin
            r_iter_count <= n_iter_count;
        end
    end

    assign busy = 1'b0;

    // x starts at the gain constant, y at zero, z at the angle
    assign w_valid[0] = start && !busy;
    assign w_vec[0]   = {GAIN_INIT, {DATA_W{1'b0}}, i_angle, r_iter_count};

    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_stage
        csc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (STAGE_IDX_W'(k)),
            .i_valid (w_valid[k]),
            .i_vec   (w_vec[k]),
            .o_valid (w_valid[k+1]),
            .o_vec   (w_vec[k+1])
        );
    end

    assign o_valid  = w_valid[MAX_ITERATIONS];
    assign o_sine   = w_vec[MAX_ITERATIONS].y;
    assign o_cosine = w_vec[MAX_ITERATIONS].x;

    `CSC_ASSERT_IMPL(a_result_has_command, o_valid, $past(start, LATENCY))
    `CSC_ASSERT_IMPL(a_count_in_range, 1'b1, r_iter_count <= CNT_W'(MAX_ITERATIONS))
    `CSC_ASSERT_IMPL(a_zero_iter_result,
                     o_valid && (w_vec[MAX_ITERATIONS].n == '0),
                     (o_cosine == GAIN_INIT) && (o_sine == '0))
    `CSC_ASSERT_NEXT(a_cfg_write_lands,
                     i_cfg_wr_en && (i_cfg_wr_data <= CNT_W'(MAX_ITERATIONS)),
                     r_iter_count == $past(i_cfg_wr_data))

endmodule
